// File: rtl/core/aos_pkg.sv
// Shared types and constants of the OBU splitter.
package aos_pkg;

  // Width of the size-field byte counter; it saturates at its top value.
  localparam int unsigned SizeCntW = 4;
  localparam logic [SizeCntW-1:0] SizeCntTop = '1;

  // Width of the declared payload length.
  localparam int unsigned SizeW = 64;

  // Byte roles.
  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_EXT     = 2'd1;
  localparam logic [1:0] ROLE_SIZE    = 2'd2;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_EXT    = 2'd1;
  localparam logic [1:0] ERR_BAD_SIZE  = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  // OBU types that are dropped downstream.
  localparam logic [3:0] TYPE_TILE_LIST = 4'd8;
  localparam logic [3:0] TYPE_PADDING   = 4'd15;

  // Header byte fields.
  localparam int unsigned HdrExtBit  = 2;
  localparam int unsigned HdrSizeBit = 1;
  localparam int unsigned HdrTypeLsb = 3;
  localparam int unsigned HdrTypeMsb = 6;

  // LEB128 continuation bit.
  localparam int unsigned LebMoreBit = 7;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_EXT    = 6'b000010,
    PH_SIZE   = 6'b000100,
    PH_SIZED  = 6'b001000,
    PH_TOEND  = 6'b010000,
    PH_SKIP   = 6'b100000
  } aos_phase_e;

  // One tagged result item.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] role;
    logic [3:0] otype;
    logic       keep;
    logic       obu_start;
    logic       obu_end;
    logic       packet_end;
    logic [1:0] error_code;
  } aos_result_t;

endpackage

// File: rtl/core/aos_parser.sv
// Byte-level OBU header and LEB128 size parser with its packet state.
module aos_parser
  import aos_pkg::*;
#(
  parameter int unsigned MAX_SIZE_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output aos_result_t result_o
);

  aos_phase_e            phase_q, phase_d;
  logic [1:0]            err_q, err_d;
  logic [3:0]            type_q, type_d;
  logic                  size_flag_q, size_flag_d;
  logic [SizeW-1:0]      accum_q, accum_d;
  logic [SizeCntW-1:0]   cnt_q, cnt_d;
  logic [SizeW-1:0]      left_q, left_d;

  logic [6:0]            shamt;
  logic [SizeW-1:0]      accum_add;
  logic [SizeW-1:0]      left_dec;
  logic [1:0]            role;
  logic                  start;
  logic                  obu_end;
  logic [1:0]            err_new;

  // Position of this size byte's seven data bits in the accumulated value.
  assign shamt     = 7'(cnt_q) * 7'd7;
  assign accum_add = accum_q | (SizeW'(data_byte_i[6:0]) << shamt);
  assign left_dec  = left_q - SizeW'(1);

  // Next-state and tag logic for the current byte.
  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    size_flag_d = size_flag_q;
    accum_d     = accum_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    role        = ROLE_PAYLOAD;
    start       = 1'b0;
    obu_end     = 1'b0;
    err_new     = ERR_NONE;

    case (phase_q)
      PH_HEADER: begin
        type_d      = data_byte_i[HdrTypeMsb:HdrTypeLsb];
        size_flag_d = data_byte_i[HdrSizeBit];
        accum_d     = '0;
        cnt_d       = '0;
        left_d      = '0;
        role        = ROLE_HEADER;
        start       = 1'b1;
        if (data_byte_i[HdrExtBit]) begin
          phase_d = PH_EXT;
          if (last_i) err_new = ERR_NO_EXT;
        end else if (data_byte_i[HdrSizeBit]) begin
          phase_d = PH_SIZE;
          if (last_i) err_new = ERR_BAD_SIZE;
        end else begin
          phase_d = PH_TOEND;
          obu_end = last_i;
        end
      end
      PH_EXT: begin
        role = ROLE_EXT;
        if (size_flag_q) begin
          phase_d = PH_SIZE;
          if (last_i) err_new = ERR_BAD_SIZE;
        end else begin
          phase_d = PH_TOEND;
          obu_end = last_i;
        end
      end
      PH_SIZE: begin
        role    = ROLE_SIZE;
        accum_d = accum_add;
        cnt_d   = (cnt_q < SizeCntTop) ? cnt_q + SizeCntW'(1) : cnt_q;
        if (data_byte_i[LebMoreBit]) begin
          if (cnt_d >= SizeCntW'(MAX_SIZE_BYTES) || last_i) err_new = ERR_BAD_SIZE;
        end else begin
          left_d = accum_add;
          if (accum_add == '0) begin
            obu_end = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            phase_d = PH_SIZED;
            if (last_i) err_new = ERR_OVERRUN;
          end
        end
      end
      PH_SIZED: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          obu_end = 1'b1;
          phase_d = PH_HEADER;
        end else if (last_i) begin
          err_new = ERR_OVERRUN;
        end
      end
      PH_TOEND: begin
        obu_end = last_i;
      end
      PH_SKIP: begin
        role = ROLE_PAYLOAD;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // An error latches and skips the rest of the packet.
    err_d = err_q;
    if (err_new != ERR_NONE) begin
      err_d   = err_new;
      phase_d = PH_SKIP;
    end
  end

  // Result tags for this byte.
  always_comb begin
    result_o.data       = data_byte_i;
    result_o.role       = role;
    result_o.otype      = type_d;
    result_o.keep       = (type_d != TYPE_TILE_LIST) && (type_d != TYPE_PADDING);
    result_o.obu_start  = start;
    result_o.obu_end    = obu_end;
    result_o.packet_end = last_i;
    result_o.error_code = err_d;
  end

  // Control state; a packet end returns the parser to its start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_HEADER;
        err_q   <= ERR_NONE;
      end else begin
        phase_q <= phase_d;
        err_q   <= err_d;
      end
    end
  end

  // Per-OBU fields; each is rewritten at a header before it is read.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      type_q      <= type_d;
      size_flag_q <= size_flag_d;
      accum_q     <= accum_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
    end
  end

endmodule

// File: rtl/core/av1_obu_splitter_unit.sv
// Top level of the OBU splitter: input register, parser and result register.
// The item passes from the input register through the parser into the result register.
// Throughput: one byte per cycle while no result is held at the output; the parser state updates in a single step.
// The input register takes a new item while a result waits to be taken only if it is empty.
// Reset (rst_ni low, asynchronous) empties both registers and starts a packet.
module av1_obu_splitter_unit
  import aos_pkg::*;
#(
  parameter int unsigned MAX_SIZE_BYTES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_packet_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] byte_role_o,
  output logic [3:0] obu_type_o,
  output logic       keep_o,
  output logic       obu_start_o,
  output logic       obu_end_o,
  output logic       packet_end_o,
  output logic [1:0] error_code_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  aos_result_t out_q;
  aos_result_t result;
  logic        in_accept;
  logic        advance;

  // Handshake: the item moves on unless a result is held by the consumer.
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_in_packet_i;
    end
  end

  // Parser.
  aos_parser #(
    .MAX_SIZE_BYTES(MAX_SIZE_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .data_byte_i(in_byte_q),
    .last_i     (in_last_q),
    .result_o   (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_out_o   = out_q.data;
  assign byte_role_o  = out_q.role;
  assign obu_type_o   = out_q.otype;
  assign keep_o       = out_q.keep;
  assign obu_start_o  = out_q.obu_start;
  assign obu_end_o    = out_q.obu_end;
  assign packet_end_o = out_q.packet_end;
  assign error_code_o = out_q.error_code;

  // A start mark only ever sits on a header byte.
  a_start_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && obu_start_o |-> byte_role_o == ROLE_HEADER)
    else $error("obu_start on a byte that is not a header");

  // A failed OBU never carries an end mark.
  a_no_end_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> !obu_end_o)
    else $error("obu_end on a byte of a failed OBU");

  // The input side stalls only while a result is held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule
